[design/pclip_pkg.sv]
// Shared types and constants for the polynomial soft clipper.
// Holds the register indexes, the order codes and the per-beat flag bundle.
// No dependencies.
package pclip_pkg;

	typedef logic [1:0] cfg_idx_t;
	typedef logic [1:0] ord_code_t;

	localparam cfg_idx_t REG_LIMIT = 2'd0;
	localparam cfg_idx_t REG_ORDER = 2'd1;

	localparam ord_code_t ORD_2 = 2'd0;
	localparam ord_code_t ORD_4 = 2'd1;
	localparam ord_code_t ORD_6 = 2'd2;

	typedef struct packed {
		logic neg;
		logic byp;
		logic ovf;
	} flags_t;

	// The unused code selects the sixth order.
	function automatic logic [2:0] order_of(ord_code_t code);
		logic [2:0] n;
		case (code)
			ORD_2: n = 3'd2;
			ORD_4: n = 3'd4;
			default: n = 3'd6;
		endcase
		return n;
	endfunction

endpackage

[design/polynomial_soft_clipper_unit.sv]
// Polynomial soft clipper: throughput one sample per cycle while out_ready does
// not hold the pipeline back.
// Depth is set by six power stages, a divide-by-order section and the
// divider, which resolves one quotient bit per stage.
// Reset clears both configuration registers to zero and empties the pipeline.
// Depends on pclip_pkg and pclip_div.
module polynomial_soft_clipper_unit #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic                          cfg_we,
	input  pclip_pkg::cfg_idx_t           cfg_index,
	input  logic [SAMPLE_BITS-2:0]        cfg_data
);

	localparam int FB = SAMPLE_BITS - 1;
	localparam int N  = FB + 1;
	localparam int K3 = FB + 3;
	localparam logic [K3-1:0] RECIP3 = K3'((64'd1 << K3) / 64'd3);
	localparam logic [FB:0]   ONE_Q  = {1'b1, {FB{1'b0}}};
	localparam logic [FB:0]   MAX_Q  = {1'b0, {FB{1'b1}}};

	logic [FB-1:0]         lim_q;
	pclip_pkg::ord_code_t  ord_q;
	logic [2:0]            ord_n;
	logic [FB:0]           lim_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= '0;
			ord_q <= pclip_pkg::ORD_2;
		end else if (cfg_we) begin
			case (cfg_index)
				pclip_pkg::REG_LIMIT: lim_q <= cfg_data;
				pclip_pkg::REG_ORDER: ord_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign ord_n   = pclip_pkg::order_of(ord_q);
	assign lim_ext = {1'b0, lim_q};

	logic [9:1]        vld_s;
	logic [9:1]        en_s;
	logic              div_in_ready;

	for (genvar k = 1; k <= 8; k++) begin : g_en
		assign en_s[k] = ~vld_s[k] | en_s[k+1];
	end
	assign en_s[9] = ~vld_s[9] | div_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en_s[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int k = 2; k <= 9; k++) begin
				if (en_s[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign in_ready = en_s[1];

	// Power stages: magnitude and knee are raised in step, one power higher per stage.
	logic [FB:0]       raw_s  [1:6];
	pclip_pkg::flags_t flg_s  [1:6];
	logic [FB:0]       mag_s  [1:6];
	logic [FB:0]       pm_s   [1:6];
	logic [FB:0]       pl_s   [1:6];
	logic [FB:0]       pmn_s  [1:6];
	logic [FB:0]       pln_s  [1:6];
	logic [FB:0]       pln1_s [1:6];

	logic [FB:0]       raw_in;
	logic [FB:0]       mag_in;
	logic              neg_in;

	assign raw_in = sample_in;
	assign neg_in = raw_in[FB];
	assign mag_in = neg_in ? (~raw_in + 1'b1) : raw_in;

	always_ff @(posedge clk) begin
		if (en_s[1]) begin
			raw_s[1]     <= raw_in;
			flg_s[1].neg <= neg_in;
			flg_s[1].byp <= (mag_in < lim_ext);
			flg_s[1].ovf <= 1'b0;
			mag_s[1]     <= mag_in;
			pm_s[1]      <= mag_in;
			pl_s[1]      <= lim_ext;
			pmn_s[1]     <= '0;
			pln_s[1]     <= '0;
			pln1_s[1]    <= (ord_n == 3'd2) ? lim_ext : '0;
		end
	end

	for (genvar k = 2; k <= 6; k++) begin : g_pow
		logic [2*FB+1:0] prod_m;
		logic [2*FB+1:0] prod_l;
		logic [FB:0]     nm;
		logic [FB:0]     nl;

		assign prod_m = pm_s[k-1] * mag_s[k-1];
		assign prod_l = pl_s[k-1] * lim_ext;
		assign nm     = prod_m[2*FB:FB];
		assign nl     = prod_l[2*FB:FB];

		always_ff @(posedge clk) begin
			if (en_s[k]) begin
				raw_s[k]  <= raw_s[k-1];
				flg_s[k]  <= flg_s[k-1];
				mag_s[k]  <= mag_s[k-1];
				pm_s[k]   <= nm;
				pl_s[k]   <= nl;
				pmn_s[k]  <= (ord_n == 3'(k)) ? nm : pmn_s[k-1];
				pln_s[k]  <= (ord_n == 3'(k)) ? nl : pln_s[k-1];
				pln1_s[k] <= (ord_n == 3'(k + 1)) ? nl : pln1_s[k-1];
			end
		end
	end

	// Stage 7: difference of powers, pre-shift by the even part of the order.
	logic [FB:0]       d_7;
	logic [FB:0]       h_s7;
	logic [FB:0]       t_s7;
	logic [FB:0]       den_s7;
	logic [FB:0]       raw_s7;
	pclip_pkg::flags_t flg_s7;

	assign d_7 = pmn_s[6] - pln_s[6];

	always_ff @(posedge clk) begin
		if (en_s[7]) begin
			case (ord_q)
				pclip_pkg::ORD_4: h_s7 <= {2'b00, d_7[FB:2]};
				default: h_s7 <= {1'b0, d_7[FB:1]};
			endcase
			t_s7   <= mag_s[6] - lim_ext;
			den_s7 <= ONE_Q - pln1_s[6];
			raw_s7 <= raw_s[6];
			flg_s7 <= flg_s[6];
		end
	end

	// Stage 8: reciprocal multiply for the division by three.
	logic [N+K3-1:0]   prod3_s8;
	logic [FB:0]       h_s8;
	logic [FB:0]       t_s8;
	logic [FB:0]       den_s8;
	logic [FB:0]       raw_s8;
	pclip_pkg::flags_t flg_s8;

	always_ff @(posedge clk) begin
		if (en_s[8]) begin
			prod3_s8 <= h_s7 * RECIP3;
			h_s8     <= h_s7;
			t_s8     <= t_s7;
			den_s8   <= den_s7;
			raw_s8   <= raw_s7;
			flg_s8   <= flg_s7;
		end
	end

	// Stage 9: the estimate is at most one short, so one correction step.
	logic [FB:0]       q0_9;
	logic [FB+2:0]     q3_9;
	logic [FB+2:0]     r_9;
	logic              six_9;
	logic [FB:0]       q_s9;
	logic [FB:0]       t_s9;
	logic [FB:0]       den_s9;
	logic [FB:0]       raw_s9;
	pclip_pkg::flags_t flg_s9;

	assign q0_9  = prod3_s8[N+K3-1:K3];
	assign q3_9  = {1'b0, q0_9, 1'b0} + {2'b00, q0_9};
	assign r_9   = {2'b00, h_s8} - q3_9;
	assign six_9 = (ord_q != pclip_pkg::ORD_2) && (ord_q != pclip_pkg::ORD_4);

	always_ff @(posedge clk) begin
		if (en_s[9]) begin
			if (!six_9) begin
				q_s9 <= h_s8;
			end else if (r_9 >= (FB+3)'(3)) begin
				q_s9 <= q0_9 + 1'b1;
			end else begin
				q_s9 <= q0_9;
			end
			t_s9   <= t_s8;
			den_s9 <= den_s8;
			raw_s9 <= raw_s8;
			flg_s9 <= flg_s8;
		end
	end

	// Numerator and early overflow, then the divider.
	logic [FB:0]       num_9;
	pclip_pkg::flags_t flg_div_in;
	logic              div_out_valid;
	logic              div_out_ready;
	pclip_pkg::flags_t div_flags;
	logic [FB:0]       div_raw;
	logic [FB:0]       div_quot;

	assign num_9 = (t_s9 > q_s9) ? (t_s9 - q_s9) : '0;

	always_comb begin
		flg_div_in     = flg_s9;
		flg_div_in.ovf = ({1'b0, num_9} >= {den_s9, 1'b0});
	end

	pclip_div #(
		.FB(FB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s[9]),
		.in_ready (div_in_ready),
		.in_flags (flg_div_in),
		.in_raw   (raw_s9),
		.in_num   (num_9),
		.in_den   (den_s9),
		.out_valid(div_out_valid),
		.out_ready(div_out_ready),
		.out_flags(div_flags),
		.out_raw  (div_raw),
		.out_quot (div_quot)
	);

	// Output register: pass bypassed samples through, else add the knee back, saturate and restore the sign.
	logic          out_valid_q;
	logic [FB:0]   res_q;
	logic [FB+1:0] y_f;
	logic [FB:0]   yneg_f;
	logic [FB:0]   res_f;

	assign div_out_ready = ~out_valid_q | out_ready;
	assign y_f = {2'b00, lim_q} + {1'b0, div_quot};

	always_comb begin
		yneg_f = (div_flags.ovf || (y_f > {1'b0, ONE_Q})) ? ONE_Q : y_f[FB:0];
		if (div_flags.byp) begin
			res_f = div_raw;
		end else if (!div_flags.neg) begin
			res_f = (div_flags.ovf || (y_f > {1'b0, MAX_Q})) ? MAX_Q : y_f[FB:0];
		end else begin
			res_f = ~yneg_f + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_out_ready) begin
			out_valid_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_out_ready) begin
			res_q <= res_f;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = res_q;

endmodule

[design/pclip_div.sv]
// Pipelined restoring divider for the soft clipper, one quotient bit per stage.
// Computes floor((num << FB) / den) for num below twice den, with sideband flags.
// Depends on pclip_pkg.
module pclip_div #(
	parameter int FB = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pclip_pkg::flags_t     in_flags,
	input  logic [FB:0]           in_raw,
	input  logic [FB:0]           in_num,
	input  logic [FB:0]           in_den,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pclip_pkg::flags_t     out_flags,
	output logic [FB:0]           out_raw,
	output logic [FB:0]           out_quot
);

	logic [FB:0]       vld_s;
	logic [FB:0]       en_s;
	logic [FB+1:0]     rem_s  [0:FB];
	logic [FB:0]       quot_s [0:FB];
	logic [FB:0]       den_s  [0:FB];
	logic [FB:0]       raw_s  [0:FB];
	pclip_pkg::flags_t flg_s  [0:FB];

	for (genvar j = 0; j <= FB; j++) begin : g_stage
		logic [FB+1:0]     rin;
		logic [FB+1:0]     rdiff;
		logic [FB:0]       qin;
		logic [FB:0]       dn;
		logic [FB:0]       rw;
		pclip_pkg::flags_t fl;
		logic              qbit;

		if (j == 0) begin : g_first
			assign rin = {1'b0, in_num};
			assign qin = '0;
			assign dn  = in_den;
			assign rw  = in_raw;
			assign fl  = in_flags;
		end else begin : g_next
			assign rin = {rem_s[j-1][FB:0], 1'b0};
			assign qin = quot_s[j-1];
			assign dn  = den_s[j-1];
			assign rw  = raw_s[j-1];
			assign fl  = flg_s[j-1];
		end

		if (j == FB) begin : g_last_en
			assign en_s[j] = ~vld_s[j] | out_ready;
		end else begin : g_mid_en
			assign en_s[j] = ~vld_s[j] | en_s[j+1];
		end

		assign qbit  = (rin >= {1'b0, dn});
		assign rdiff = rin - {1'b0, dn};

		always_ff @(posedge clk) begin
			if (en_s[j]) begin
				rem_s[j]  <= qbit ? rdiff : rin;
				quot_s[j] <= {qin[FB-1:0], qbit};
				den_s[j]  <= dn;
				raw_s[j]  <= rw;
				flg_s[j]  <= fl;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en_s[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int j = 1; j <= FB; j++) begin
				if (en_s[j]) begin
					vld_s[j] <= vld_s[j-1];
				end
			end
		end
	end

	assign in_ready  = en_s[0];
	assign out_valid = vld_s[FB];
	assign out_flags = flg_s[FB];
	assign out_raw   = raw_s[FB];
	assign out_quot  = quot_s[FB];

endmodule

[dv/polynomial_soft_clipper_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for polynomial_soft_clipper_unit: drives samples over valid/ready
// and checks every output beat against a bit-true model of the clipping curve.
// Depends on pclip_pkg and the clipper RTL.
module polynomial_soft_clipper_unit_tb;

	localparam int FRAC = 15;
	localparam logic [63:0] ONE_Q = 64'd1 << FRAC;
	localparam pclip_pkg::cfg_idx_t REG_SPARE_A = 2'd2;
	localparam pclip_pkg::cfg_idx_t REG_SPARE_B = 2'd3;
	localparam pclip_pkg::ord_code_t ORD_SPARE = 2'd3;
	localparam int PHASE_ITEMS = 160;
	localparam int RANDOM_PHASES = 12;

	class clip_scoreboard;
		logic [14:0] knee;
		pclip_pkg::ord_code_t order_code;
		logic [15:0] pending_shaped[$];
		int mismatches;
		int samples_checked;
		int curve_count;
		int bypass_count;

		function new();
			knee = '0;
			order_code = pclip_pkg::ORD_2;
			mismatches = 0;
			samples_checked = 0;
			curve_count = 0;
			bypass_count = 0;
		endfunction

		function void write_reg(pclip_pkg::cfg_idx_t idx, logic [14:0] data);
			case (idx)
				pclip_pkg::REG_LIMIT: begin
					knee = data;
				end
				pclip_pkg::REG_ORDER: begin
					order_code = data[1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function logic [63:0] trunc_pow(logic [63:0] v, int k);
			logic [63:0] p;
			int i;
			p = v;
			for (i = 1; i < k; i++)
				p = (p * v) >> FRAC;
			return p;
		endfunction

		function logic [15:0] shaped_sample(logic [15:0] raw);
			logic neg;
			logic [63:0] mag, lim, d, q, t, num, den, y;
			int n;
			neg = raw[15];
			lim = 64'(knee);
			mag = neg ? (64'd65536 - 64'(raw)) : 64'(raw);
			case (order_code)
				pclip_pkg::ORD_2: n = 2;
				pclip_pkg::ORD_4: n = 4;
				default: n = 6;
			endcase
			if (mag < lim)
				return raw;
			d = trunc_pow(mag, n) - trunc_pow(lim, n);
			q = d / 64'(n);
			t = mag - lim;
			num = (t > q) ? (t - q) : 64'd0;
			den = ONE_Q - trunc_pow(lim, n - 1);
			if (den == 64'd0)
				den = 64'd1;
			y = lim + ((num << FRAC) / den);
			if (!neg)
				return (y > ONE_Q - 64'd1) ? 16'h7fff : y[15:0];
			if (y > ONE_Q)
				y = ONE_Q;
			return 16'(64'd65536 - y);
		endfunction

		function void note_sample(logic [15:0] raw);
			logic [63:0] mag;
			mag = raw[15] ? (64'd65536 - 64'(raw)) : 64'(raw);
			if (mag < 64'(knee))
				bypass_count++;
			else
				curve_count++;
			pending_shaped.push_back(shaped_sample(raw));
		endfunction

		task report(string what);
			mismatches++;
			$display("MISMATCH at %0t ns: %s", $time, what);
		endtask

		task check_sample(logic [15:0] got);
			logic [15:0] want;
			if (pending_shaped.size() == 0) begin
				report($sformatf("output beat 0x%04h with no sample pending", got));
			end else begin
				want = pending_shaped.pop_front();
				samples_checked++;
				if (got !== want)
					report($sformatf("sample_out 0x%04h, expected 0x%04h", got, want));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] sample_in;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] sample_out;
	logic cfg_we;
	pclip_pkg::cfg_idx_t cfg_index;
	logic [14:0] cfg_data;

	clip_scoreboard sb = new();
	logic [15:0] directed_q[$];
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit rx_hold = 1'b0;
	int settings_seen = 1;

	polynomial_soft_clipper_unit #(.SAMPLE_BITS(16)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [15:0] pick_sample();
		int m;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 16'($urandom);
			4, 5: m = int'(sb.knee) + int'($urandom_range(0, 8)) - 4;
			6: m = $urandom_range(0, 1) ? 32768 :
				($urandom_range(0, 1) ? 32767 : int'($urandom_range(0, 2)));
			default: m = int'(sb.knee) + int'($urandom_range(0, 32768 - int'(sb.knee)));
		endcase
		if (m < 0)
			m = 0;
		if (m > 32768)
			m = 32768;
		return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
	endfunction

	task automatic cfg_write(pclip_pkg::cfg_idx_t idx, logic [14:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic set_curve(logic [14:0] lim, pclip_pkg::ord_code_t code);
		cfg_write(pclip_pkg::REG_LIMIT, lim);
		cfg_write(pclip_pkg::REG_ORDER, {13'($urandom), code});
		cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 15'($urandom));
		cfg_we <= 1'b0;
		settings_seen++;
	endtask

	task automatic stream(int count);
		int total, gap, i;
		logic [15:0] v;
		total = count + directed_q.size();
		for (i = 0; i < total; i++) begin
			gap = tx_calm ? 0 : $urandom_range(0, 7);
			v = (directed_q.size() > 0) ? directed_q.pop_front() : pick_sample();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			sample_in <= v;
			do @(posedge clk); while (!in_ready);
			sb.note_sample(v);
		end
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending_shaped.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, 7);
			if (rx_hold) begin
				stall = 200;
				rx_hold = 1'b0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_sample(sample_out);
		end
	end

	initial begin
		#1_000_000;
		$display("polynomial_soft_clipper_unit verification failed");
		$finish;
	end

	initial begin
		int p;
		logic [14:0] lim;
		pclip_pkg::ord_code_t code;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		sample_in <= '0;
		cfg_we <= 1'b0;
		cfg_index <= pclip_pkg::REG_LIMIT;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_q = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000};
		stream(0);
		drain();
		set_curve(15'd16384, pclip_pkg::ORD_4);
		directed_q = '{16'h4000, 16'hc000, 16'h3fff, 16'hc001,
			16'h4e20, 16'hb1e0, 16'h7fff, 16'h8000};
		stream(0);
		drain();
		set_curve(15'h7fff, ORD_SPARE);
		directed_q = '{16'h7fff, 16'h8001, 16'h8000, 16'h7ffe, 16'h0000};
		stream(0);
		drain();
		set_curve(15'd1, pclip_pkg::ORD_6);
		directed_q = '{16'h0001, 16'hffff, 16'h0000, 16'h3039, 16'h8000};
		stream(0);
		drain();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin lim = 15'd0; code = pclip_pkg::ORD_2; end
				1: begin lim = 15'h7fff; code = pclip_pkg::ORD_6; end
				2: begin lim = 15'd1; code = ORD_SPARE; end
				3: begin lim = 15'd16384; code = pclip_pkg::ORD_4; end
				4: begin lim = 15'h7ffe; code = pclip_pkg::ORD_2; end
				default: begin
					lim = $urandom_range(0, 1) ? 15'($urandom) : 15'($urandom_range(0, 1024));
					code = pclip_pkg::ord_code_t'($urandom_range(0, 3));
				end
			endcase
			set_curve(lim, code);
			tx_calm = (p % 3 == 1) || (p == 3);
			rx_calm = (p % 4 == 2);
			if (p == 3)
				rx_hold = 1'b1;
			stream(PHASE_ITEMS);
			drain();
		end

		rx_calm = 1'b1;
		repeat (40) @(posedge clk);
		$display("Checked %0d samples over %0d knee and order settings,",
			sb.samples_checked, settings_seen);
		$display("%0d on the curve and %0d passed through; mismatches seen: %0d.",
			sb.curve_count, sb.bypass_count, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_shaped.size() == 0) begin
			$display("polynomial_soft_clipper_unit verification clean");
		end else begin
			$display("polynomial_soft_clipper_unit verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
design/pclip_pkg.sv
design/pclip_div.sv
design/polynomial_soft_clipper_unit.sv
dv/polynomial_soft_clipper_unit_tb.sv
